// ===== rtl/core/bal_pkg.sv =====
package bal_pkg;

  typedef enum logic [2:0] {
    FUNC_APPEND    = 3'd0,
    FUNC_OVERWRITE = 3'd1,
    FUNC_REMOVE    = 3'd2,
    FUNC_READ      = 3'd3,
    FUNC_SEARCH    = 3'd4,
    FUNC_COUNT     = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_EMPTY    = 3'd2,
    STATUS_BADPOS   = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_e;

  localparam int unsigned PosW   = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 9;

endpackage

// ===== rtl/core/bounded_array_list.sv =====
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+---------------------------
// request  | func_i, position_i, value_i                   | start high, busy low
// result   | status_o, read_data_o, found_index_o,         | done_o strobe, one cycle,
//          | fill_count_o                                  | cannot be held off
// After accept: append, overwrite, count and unused codes end in the exec state; read adds
// the read state; inner remove shifts later entries down in the shift state; search scans
// to a match or the end in the scan state. The single read port of the entry store sets these.
// busy stays high from the accept edge until the result strobe; one request at a time.
// Reset clears the fill count and the sequencer; entry contents stay undefined.
module bounded_array_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    func_i,
  input  logic [bal_pkg::PosW-1:0]      position_i,
  input  logic signed [bal_pkg::WordW-1:0] value_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic signed [bal_pkg::WordW-1:0] read_data_o,
  output logic [bal_pkg::PosW-1:0]      found_index_o,
  output logic [bal_pkg::CountW-1:0]    fill_count_o
);
  import bal_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_SCAN  = 5'b01000,
    S_READ  = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             idx_q, idx_d;
  func_e                     func_q;
  logic [PosW-1:0]           pos_q;
  logic [WordW-1:0]          val_q;
  logic                      done_q, done_d;
  status_e                   status_q, status_d;
  logic [WordW-1:0]          rdata_out_q, rdata_out_d;
  logic [PosW-1:0]           fidx_q, fidx_d;

  logic [WordW-1:0]          mem_q [DEPTH];
  logic [WordW-1:0]          mem_rd_q;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [WordW-1:0]          wdata;
  logic [CountW-1:0]         raddr;

  logic                      accept;
  logic [CountW-1:0]         cnt9;
  logic [CountW-1:0]         pos9;
  logic [CountW-1:0]         idx9;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cnt9   = CountW'(count_q);
  assign pos9   = CountW'(pos_q);
  assign idx9   = CountW'(idx_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    done_d      = 1'b0;
    status_d    = STATUS_OK;
    rdata_out_d = '0;
    fidx_d      = '0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = mem_rd_q;
    raddr       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (func_q)
          FUNC_APPEND: begin
            if (cnt9 >= CountW'(DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              we      = 1'b1;
              waddr   = count_q[AW-1:0];
              wdata   = val_q;
              count_d = count_q + CW'(1);
            end
          end
          FUNC_OVERWRITE: begin
            if (pos9 >= cnt9) begin
              status_d = STATUS_BADPOS;
            end else begin
              we    = 1'b1;
              waddr = pos_q[AW-1:0];
              wdata = val_q;
            end
          end
          FUNC_REMOVE: begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else if (pos9 >= cnt9) begin
              status_d = STATUS_BADPOS;
            end else if (pos9 + CountW'(1) >= cnt9) begin
              count_d = count_q - CW'(1);
            end else begin
              raddr   = pos9 + CountW'(1);
              idx_d   = pos_q[AW-1:0];
              state_d = S_SHIFT;
              done_d  = 1'b0;
            end
          end
          FUNC_READ: begin
            if (pos9 >= cnt9) begin
              status_d = STATUS_BADPOS;
            end else begin
              raddr   = pos9;
              state_d = S_READ;
              done_d  = 1'b0;
            end
          end
          FUNC_SEARCH: begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              raddr   = '0;
              idx_d   = '0;
              state_d = S_SCAN;
              done_d  = 1'b0;
            end
          end
          FUNC_COUNT: begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end
          end
          default: begin
            status_d = STATUS_OK;
          end
        endcase
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = mem_rd_q;
        raddr = idx9 + CountW'(2);
        idx_d = idx_q + AW'(1);
        if (idx9 + CountW'(2) >= cnt9) begin
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_SCAN: begin
        raddr = idx9 + CountW'(1);
        idx_d = idx_q + AW'(1);
        if (mem_rd_q == val_q) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          fidx_d  = PosW'(idx_q);
        end else if (idx9 + CountW'(1) >= cnt9) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = STATUS_NOTFOUND;
        end
      end
      S_READ: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        rdata_out_d = mem_rd_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    status_q    <= status_d;
    rdata_out_q <= rdata_out_d;
    fidx_q      <= fidx_d;
    if (accept) begin
      func_q <= func_e'(func_i);
      pos_q  <= position_i;
      val_q  <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    mem_rd_q <= mem_q[raddr[AW-1:0]];
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_data_o   = rdata_out_q;
  assign found_index_o = fidx_q;
  assign fill_count_o  = CountW'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CountW'(count_q) <= CountW'(DEPTH))
    else $error("fill count beyond depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("request accepted without going busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> fill_count_o == CountW'(DEPTH))
    else $error("full reported below depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(count_q))
    else $error("fill count moved without a result");

endmodule
